>>> sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int POS_W       = 6;
	localparam int DATA_W      = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic                     opcode;
		logic [DATA_W-1:0]        payload_in;
		logic signed [DATA_W-1:0] priority_in;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]         insert_position;
		logic [DATA_W-1:0]        payload_out;
		logic signed [DATA_W-1:0] priority_out;
		logic                     was_empty;
		logic                     rejected_full;
	} rsp_t;

	// one stored entry, as handed between neighbouring cells
	typedef struct packed {
		logic                     valid;
		logic [DATA_W-1:0]        payload;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic [DATA_W-1:0]        payload;
		logic signed [DATA_W-1:0] prio;
	} cell_cmd_t;

	localparam entry_t ENTRY_NONE = '{valid: 1'b0, payload: '0, prio: '0};

endpackage

>>> sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | req_t: opcode, payload_in, priority_in
// rsp     | out | rsp_valid / rsp_stall | rsp_t: insert_position, payload_out,
//         |     |                       |        priority_out, was_empty, rejected_full
//
// One request per cycle while req_stall is low: every cell compares and shifts
// in the cycle the request is taken, and the response is registered for rsp.
// Reset clears only the cell valid bits and the output control; stored data is
// left as is. A stalled response is held, a second one is caught in a skid
// register and req_stall rises only while that skid register is occupied.

module sorted_priority_queue import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	entry_t    entries [QUEUE_DEPTH];
	logic      keeps   [QUEUE_DEPTH];
	logic      heres   [QUEUE_DEPTH];
	cell_cmd_t cmd;

	logic accept;
	logic full;
	logic empty;
	rsp_t result;

	logic rsp_valid_q;
	rsp_t rsp_q;
	logic skid_valid_q;
	rsp_t skid_q;

	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !req_stall;

	// queue stays packed towards the head, so the end cells tell fill state
	assign empty = !entries[0].valid;
	assign full  = entries[QUEUE_DEPTH-1].valid;

	assign cmd.ins     = accept && (req.opcode == OP_INSERT) && !full;
	assign cmd.rem     = accept && (req.opcode == OP_REMOVE) && !empty;
	assign cmd.payload = req.payload_in;
	assign cmd.prio    = req.priority_in;

	// the row of cells: each looks at its neighbours only
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;

		if (i == 0) begin : g_first
			assign left_e = ENTRY_NONE;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_k = keeps[i-1];
		end

		if (i == QUEUE_DEPTH-1) begin : g_last
			assign right_e = ENTRY_NONE;
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.is_head   (i == 0),
			.left      (left_e),
			.left_keep (left_k),
			.right     (right_e),
			.entry     (entries[i]),
			.keep      (keeps[i]),
			.here      (heres[i])
		);
	end

	// response for the request being taken; position is one-hot to index
	always_comb begin
		result = '0;
		if (req.opcode == OP_INSERT) begin
			if (full) begin
				result.rejected_full = 1'b1;
			end else begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (heres[i]) begin
						result.insert_position = result.insert_position | POS_W'(i);
					end
				end
			end
		end else begin
			if (empty) begin
				result.was_empty = 1'b1;
			end else begin
				result.payload_out  = entries[0].payload;
				result.priority_out = entries[0].prio;
			end
		end
	end

	// output register with skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid_q || !rsp_stall) begin
			rsp_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid_q || !rsp_stall) begin
			rsp_q <= skid_valid_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  logic      is_head,
	input  entry_t    left,
	input  logic      left_keep,
	input  entry_t    right,
	output entry_t    entry,
	output logic      keep,
	output logic      here
);

	logic                     valid_q;
	logic [DATA_W-1:0]        payload_q;
	logic signed [DATA_W-1:0] prio_q;

	// head keeps its place on a tie, the rest only when strictly greater
	assign keep = valid_q && ((prio_q > cmd.prio) || (is_head && (prio_q == cmd.prio)));
	assign here = !keep && left_keep;

	assign entry = '{valid: valid_q, payload: payload_q, prio: prio_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rem) begin
			valid_q <= right.valid;
		end else if (cmd.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			payload_q <= right.payload;
			prio_q    <= right.prio;
		end else if (cmd.ins && !keep) begin
			payload_q <= left_keep ? cmd.payload : left.payload;
			prio_q    <= left_keep ? cmd.prio : left.prio;
		end
	end

endmodule
